### rtl/twrdp_pkg.sv
// Shared types and constants for the ternary-weight row dot product.
// No dependencies; imported by every module of the block.
package twrdp_pkg;

    // 2-bit weight codes, decoded as code minus one
    localparam logic [1:0] W_NEG  = 2'd0;
    localparam logic [1:0] W_ZERO = 2'd1;
    localparam logic [1:0] W_POS  = 2'd2;
    localparam logic [1:0] W_DBL  = 2'd3;

    // configuration register indexes
    localparam logic CFG_SCALE = 1'b0;
    localparam logic CFG_START = 1'b1;

    localparam logic [31:0] SCALE_RESET = 32'd16777216;

    localparam int LANES    = 4;
    localparam int ACT_W    = 8;
    localparam int PROD_W   = 10;
    localparam int PSUM_W   = 12;
    localparam int SCALE_W  = 32;
    localparam int ROW_W    = 16;
    localparam int SUM_W    = 32;
    localparam int SCALED_W = 64;
    // accumulator is sign-extended to this width and split in two halves
    localparam int MUL_EXT_W  = 48;
    localparam int MUL_HALF_W = MUL_EXT_W / 2;

    typedef logic signed [ACT_W-1:0]    act_t;
    typedef logic signed [PROD_W-1:0]   prod_t;
    typedef logic signed [PSUM_W-1:0]   psum_t;
    typedef logic signed [SCALE_W-1:0]  scale_t;
    typedef logic signed [SCALED_W-1:0] scaled_t;

    // request handed from the accumulator to the multiplier stages
    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
    } row_ctl_t;

endpackage

### rtl/ternary_weight_row_dot_product_top.sv
// Top level of the ternary-weight row dot product.
// Depends on twrdp_pkg, twrdp_lane, twrdp_merge and twrdp_mul.

// Takes one packed weight byte with four int8 activations per cycle; four
// lanes decode the 2-bit codes (code minus one, code 3 gives +2) and a merge
// stage adds the products into a wrapping ACC_WIDTH-bit row accumulator, so
// the sustained rate is one item per clock while the output is not stalled.
// A row closed by last_in_row passes the first stage, the multiplier's
// partial-product stage and the output register, and leaves with its index,
// its sum and the sum times the Q8.24 scale. Stages hold while the output
// is stalled; up to three finished rows may be in flight. Writing start_row
// reloads the row counter; a scale write applies to rows not yet past s1_reg.
module ternary_weight_row_dot_product_top #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wen,
    input  logic                       cfg_index,
    input  logic [31:0]                cfg_wdata,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [7:0]                 s_weight_byte,
    input  twrdp_pkg::act_t            s_act_a,
    input  twrdp_pkg::act_t            s_act_b,
    input  twrdp_pkg::act_t            s_act_c,
    input  twrdp_pkg::act_t            s_act_d,
    input  logic                       s_last_in_row,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [15:0]                m_row_index,
    output logic signed [31:0]         m_row_sum,
    output twrdp_pkg::scaled_t         m_scaled_sum
);
    import twrdp_pkg::*;

    logic                        s_acc;
    act_t                        acts [LANES];
    prod_t                       prods [LANES];
    logic signed [ACC_WIDTH-1:0] total;

    scale_t           scale_reg;
    logic [ROW_W-1:0] row_cnt_reg;

    row_ctl_t                    s1_reg, s2_reg;
    logic signed [ACC_WIDTH-1:0] s1_acc_reg;
    logic signed [SUM_W-1:0]     s2_sum_reg, out_sum_reg;
    logic [ROW_W-1:0]            out_row_reg;
    logic                        out_valid_reg;
    logic                        out_en, s2_en, s1_en;

    assign acts[0] = s_act_a;
    assign acts[1] = s_act_b;
    assign acts[2] = s_act_c;
    assign acts[3] = s_act_d;

    for (genvar i = 0; i < LANES; i++) begin : g_lane
        twrdp_lane u_lane (
            .code (s_weight_byte[2*(LANES-1-i) +: 2]),
            .act  (acts[i]),
            .prod (prods[i])
        );
    end

    twrdp_merge #(.ACC_WIDTH(ACC_WIDTH)) u_merge (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_acc),
        .last    (s_last_in_row),
        .prod    (prods),
        .total   (total)
    );

    // each stage advances when it is empty or the one after it moves
    assign out_en  = !out_valid_reg || m_ready;
    assign s2_en   = !s2_reg.valid || out_en;
    assign s1_en   = !s1_reg.valid || s2_en;
    assign s_ready = s1_en;
    assign s_acc   = s_valid && s_ready;

    twrdp_mul #(.ACC_WIDTH(ACC_WIDTH)) u_mul (
        .aclk    (aclk),
        .ld_pp   (s1_reg.valid && s2_en),
        .ld_sum  (s2_reg.valid && out_en),
        .acc     (s1_acc_reg),
        .scale   (scale_reg),
        .product (m_scaled_sum)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= SCALE_RESET;
            row_cnt_reg   <= '0;
            s1_reg.valid  <= 1'b0;
            s2_reg.valid  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wen && cfg_index == CFG_SCALE) begin
                scale_reg <= cfg_wdata;
            end
            if (cfg_wen && cfg_index == CFG_START) begin
                row_cnt_reg <= cfg_wdata[ROW_W-1:0];
            end else if (s_acc && s_last_in_row) begin
                row_cnt_reg <= row_cnt_reg + ROW_W'(1);
            end
            if (s1_en) begin
                s1_reg.valid <= s_acc && s_last_in_row;
                s1_reg.row   <= row_cnt_reg;
            end
            if (s2_en) begin
                s2_reg.valid <= s1_reg.valid;
                s2_reg.row   <= s1_reg.row;
            end
            if (out_en) begin
                out_valid_reg <= s2_reg.valid;
            end
        end
    end

    // payload: no reset
    always_ff @(posedge aclk) begin
        if (s1_en) begin
            s1_acc_reg <= total;
        end
        if (s2_en) begin
            s2_sum_reg <= SUM_W'(s1_acc_reg);
        end
        if (out_en) begin
            out_row_reg <= s2_reg.row;
            out_sum_reg <= s2_sum_reg;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_row_index = out_row_reg;
    assign m_row_sum   = out_sum_reg;

    a_last_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && s_last_in_row) |=> s1_reg.valid)
        else $error("finished row did not enter the multiplier stage");

    a_row_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !s_last_in_row && !cfg_wen) |=> $stable(row_cnt_reg))
        else $error("row counter moved inside a row");

    a_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        (cfg_wen && cfg_index == CFG_START) |=> row_cnt_reg == $past(cfg_wdata[ROW_W-1:0]))
        else $error("start_row write did not load the row counter");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_reg.valid && s2_reg.valid && m_valid && !m_ready) |-> !s_ready)
        else $error("request taken while all stages are held");

endmodule

### rtl/twrdp_lane.sv
// One lane: decodes a 2-bit weight code and applies it to one activation.
// Depends on twrdp_pkg.
module twrdp_lane (
    input  logic [1:0]      code,
    input  twrdp_pkg::act_t act,
    output twrdp_pkg::prod_t prod
);
    import twrdp_pkg::*;

    prod_t act_ext;

    assign act_ext = PROD_W'(act);

    always_comb begin
        case (code)
            W_NEG:   prod = -act_ext;
            W_ZERO:  prod = '0;
            W_POS:   prod = act_ext;
            W_DBL:   prod = act_ext <<< 1;
            default: prod = '0;
        endcase
    end

endmodule

### rtl/twrdp_merge.sv
// Merging stage: adds the four lane products into the row accumulator.
// Depends on twrdp_pkg.
module twrdp_merge #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            accept,
    input  logic                            last,
    input  twrdp_pkg::prod_t                prod [twrdp_pkg::LANES],
    output logic signed [ACC_WIDTH-1:0]     total
);
    import twrdp_pkg::*;

    logic signed [ACC_WIDTH-1:0] acc_reg, acc_next;
    psum_t                       psum;

    always_comb begin
        psum = '0;
        for (int i = 0; i < LANES; i++) begin
            psum = psum + PSUM_W'(prod[i]);
        end
    end

    assign total = acc_reg + ACC_WIDTH'(psum);

    always_comb begin
        acc_next = acc_reg;
        if (accept) begin
            // clear once the row is handed on
            acc_next = last ? '0 : total;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else begin
            acc_reg <= acc_next;
        end
    end

endmodule

### rtl/twrdp_mul.sv
// Two-stage signed multiplier: accumulator times Q8.24 scale, split in halves.
// Depends on twrdp_pkg.
module twrdp_mul #(
    parameter int ACC_WIDTH = 32
) (
    input  logic                        aclk,
    input  logic                        ld_pp,
    input  logic                        ld_sum,
    input  logic signed [ACC_WIDTH-1:0] acc,
    input  twrdp_pkg::scale_t           scale,
    output twrdp_pkg::scaled_t          product
);
    import twrdp_pkg::*;

    localparam int LO_PP_W = MUL_HALF_W + 1 + SCALE_W;
    localparam int HI_PP_W = MUL_HALF_W + SCALE_W;

    logic signed [MUL_EXT_W-1:0]  acc_ext;
    logic signed [MUL_HALF_W:0]   lo_half;
    logic signed [MUL_HALF_W-1:0] hi_half;
    logic signed [LO_PP_W-1:0]    lo_pp_reg;
    logic signed [HI_PP_W-1:0]    hi_pp_reg;
    scaled_t                      product_reg;

    assign acc_ext = MUL_EXT_W'(acc);
    // low half is unsigned, high half carries the sign
    assign lo_half = {1'b0, acc_ext[MUL_HALF_W-1:0]};
    assign hi_half = acc_ext[MUL_EXT_W-1:MUL_HALF_W];

    always_ff @(posedge aclk) begin
        if (ld_pp) begin
            lo_pp_reg <= LO_PP_W'(lo_half) * LO_PP_W'(scale);
            hi_pp_reg <= HI_PP_W'(hi_half) * HI_PP_W'(scale);
        end
        if (ld_sum) begin
            product_reg <= (SCALED_W'(hi_pp_reg) <<< MUL_HALF_W) + SCALED_W'(lo_pp_reg);
        end
    end

    assign product = product_reg;

endmodule

### dv/tb.sv
// Self-checking bench for ternary_weight_row_dot_product_top: drives packed weight
// requests and register writes, predicts every finished row and checks the result port.
// Depends on twrdp_pkg and the RTL under rtl/.
module tb;
    import twrdp_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_PHASES = 7;
    localparam int PHASE_REQUESTS = 250;

    typedef struct {
        logic [15:0]        row_index;
        logic signed [31:0] row_sum;
        logic signed [63:0] scaled_sum;
    } row_result_t;

    // Keeps its own accumulator, row counter and scale, and the finished rows still owed.
    class row_sum_tracker;
        logic signed [31:0] acc;
        logic signed [31:0] scale;
        logic [15:0]        row_count;
        row_result_t        due_rows[$];
        int                 errors;

        function new();
            acc = '0;
            scale = SCALE_RESET;
            row_count = '0;
            errors = 0;
        endfunction

        function int pending();
            return due_rows.size();
        endfunction

        function int weight_of(logic [1:0] code);
            case (code)
                W_NEG:   return -1;
                W_ZERO:  return 0;
                W_POS:   return 1;
                default: return 2;
            endcase
        endfunction

        function void write_reg(logic idx, logic [31:0] data);
            case (idx)
                CFG_SCALE: scale = data;
                // restart the row numbering, keep the accumulator
                CFG_START: row_count = data[15:0];
                default:   ;
            endcase
        endfunction

        function void note_request(logic [7:0] wb, act_t a, act_t b, act_t c, act_t d,
                                   logic last);
            int          terms;
            longint      wide_acc;
            longint      wide_scale;
            row_result_t res;
            terms = weight_of(wb[7:6]) * a + weight_of(wb[5:4]) * b
                  + weight_of(wb[3:2]) * c + weight_of(wb[1:0]) * d;
            acc = acc + terms;
            if (last) begin
                wide_acc = acc;
                wide_scale = scale;
                res.row_index = row_count;
                res.row_sum = acc;
                res.scaled_sum = wide_acc * wide_scale;
                due_rows.push_back(res);
                acc = '0;
                row_count = row_count + 16'd1;
            end
        endfunction

        function void check_row(logic [15:0] idx, logic signed [31:0] sum,
                                logic signed [63:0] scaled);
            row_result_t exp_row;
            if (due_rows.size() == 0) begin
                $display("%0t unexpected row: index %0d sum %0d scaled %0d",
                         $time, idx, sum, scaled);
                errors++;
                return;
            end
            exp_row = due_rows.pop_front();
            if (idx !== exp_row.row_index) begin
                $display("%0t row_index: expected %0d, got %0d", $time, exp_row.row_index, idx);
                errors++;
            end
            if (sum !== exp_row.row_sum) begin
                $display("%0t row_sum: expected %0d, got %0d", $time, exp_row.row_sum, sum);
                errors++;
            end
            if (scaled !== exp_row.scaled_sum) begin
                $display("%0t scaled_sum: expected %0d, got %0d",
                         $time, exp_row.scaled_sum, scaled);
                errors++;
            end
        endfunction
    endclass

    logic               aclk = 1'b0;
    logic               aresetn = 1'b0;
    logic               cfg_wen = 1'b0;
    logic               cfg_index = 1'b0;
    logic [31:0]        cfg_wdata = '0;
    logic               s_valid = 1'b0;
    logic               s_ready;
    logic [7:0]         s_weight_byte = '0;
    act_t               s_act_a = '0;
    act_t               s_act_b = '0;
    act_t               s_act_c = '0;
    act_t               s_act_d = '0;
    logic               s_last_in_row = 1'b0;
    logic               m_valid;
    logic               m_ready = 1'b0;
    logic [15:0]        m_row_index;
    logic signed [31:0] m_row_sum;
    scaled_t            m_scaled_sum;

    row_sum_tracker rows = new();
    int stalled_cycles = 0;

    ternary_weight_row_dot_product_top #(.ACC_WIDTH(32)) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wen       (cfg_wen),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_weight_byte (s_weight_byte),
        .s_act_a       (s_act_a),
        .s_act_b       (s_act_b),
        .s_act_c       (s_act_c),
        .s_act_d       (s_act_d),
        .s_last_in_row (s_last_in_row),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_row_index   (m_row_index),
        .m_row_sum     (m_row_sum),
        .m_scaled_sum  (m_scaled_sum)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn && cfg_wen)
            rows.write_reg(cfg_index, cfg_wdata);
        if (aresetn && s_valid && s_ready)
            rows.note_request(s_weight_byte, s_act_a, s_act_b, s_act_c, s_act_d,
                              s_last_in_row);
        if (aresetn && m_valid && m_ready)
            rows.check_row(m_row_index, m_row_sum, m_scaled_sum);
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stalled_cycles <= 0;
        else
            stalled_cycles <= stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic act_t pick_act();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return -8'sd128;
            1:       return 8'sd127;
            2:       return 8'sd0;
            default: return act_t'($urandom);
        endcase
    endfunction

    function automatic int pick_row_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40)
            return $urandom_range(1, 4);
        else if (r < 85)
            return $urandom_range(5, 16);
        return $urandom_range(17, 80);
    endfunction

    function automatic logic [31:0] pick_scale();
        int r;
        r = $urandom_range(0, 5);
        case (r)
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0;
            3:       return SCALE_RESET;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_start();
        logic [31:0] v;
        int          r;
        v = $urandom;
        r = $urandom_range(0, 3);
        if (r == 0)
            v[15:0] = 16'h0000;
        else if (r == 1)
            v[15:0] = 16'hFFFF;
        return v;
    endfunction

    // return at the edge where the request is taken; valid stays up for the next one
    task automatic send_request(input logic [7:0] wb, input act_t a, input act_t b,
                                input act_t c, input act_t d, input logic last,
                                input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_weight_byte <= wb;
        s_act_a <= a;
        s_act_b <= b;
        s_act_c <= c;
        s_act_d <= d;
        s_last_in_row <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // hold off until every owed row is out and the pipeline has had time to settle
    task automatic drain();
        s_valid <= 1'b0;
        do @(posedge aclk); while (rows.pending() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] data);
        cfg_wen <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
    endtask

    task automatic end_writes();
        cfg_wen <= 1'b0;
        @(posedge aclk);
    endtask

    initial begin
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 12)) @(posedge aclk);
            m_ready <= 1'b0;
            if ($urandom_range(0, 9) == 0)
                repeat ($urandom_range(8, 40)) @(posedge aclk);
            else
                repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    end

    initial begin
        int row_left;
        bit quiet;
        row_left = 0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // rows at the weight and activation extremes, mostly of one request, reset scale
        send_request(8'h00, -8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b1, pick_gap());
        send_request(8'hFF, -8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b1, pick_gap());
        send_request(8'hFF, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b1, pick_gap());
        send_request(8'h55, 8'sd5, -8'sd7, 8'sd100, -8'sd128, 1'b1, pick_gap());
        send_request(8'hAA, 8'sd1, 8'sd2, 8'sd3, 8'sd4, 1'b0, pick_gap());
        send_request(8'h1B, 8'sd10, 8'sd20, 8'sd30, 8'sd40, 1'b0, pick_gap());
        send_request(8'hE4, -8'sd1, -8'sd2, -8'sd3, -8'sd4, 1'b1, pick_gap());
        send_request(8'h00, 8'sd0, 8'sd0, 8'sd0, 8'sd0, 1'b1, pick_gap());
        // leave a row open across the restart
        send_request(8'hFF, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b0, pick_gap());
        drain();

        // most negative scale; row counter wraps after 16'hFFFF
        write_reg(CFG_SCALE, 32'h8000_0000);
        write_reg(CFG_START, {16'hA5C3, 16'hFFFF});
        end_writes();
        send_request(8'hFF, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b1, 0);
        send_request(8'h00, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b1, 0);
        send_request(8'hFF, -8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b1, 0);
        send_request(8'hAA, -8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b0, 0);
        drain();

        write_reg(CFG_SCALE, 32'h7FFF_FFFF);
        write_reg(CFG_START, 32'h0000_8000);
        end_writes();
        send_request(8'hFF, -8'sd128, -8'sd128, -8'sd128, -8'sd128, 1'b1, pick_gap());
        send_request(8'hFF, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b1, pick_gap());
        drain();

        write_reg(CFG_SCALE, 32'h0);
        end_writes();
        send_request(8'hAA, 8'sd127, 8'sd127, 8'sd127, 8'sd127, 1'b1, pick_gap());
        send_request(8'h27, -8'sd128, 8'sd127, -8'sd1, 8'sd1, 1'b1, pick_gap());

        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            drain();
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_SCALE, pick_scale());
            if ($urandom_range(0, 3) != 0)
                write_reg(CFG_START, pick_start());
            end_writes();
            // every third phase runs back to back from the sender
            quiet = (phase % 3 == 1);
            for (int n = 0; n < PHASE_REQUESTS; n++) begin
                if (row_left == 0)
                    row_left = pick_row_len();
                row_left--;
                send_request(8'($urandom), pick_act(), pick_act(), pick_act(), pick_act(),
                             row_left == 0, quiet ? 0 : pick_gap());
            end
        end
        drain();

        if (rows.errors == 0 && rows.pending() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
